### hdl/fs_pkg.sv
package fs_pkg;

    // Storage sizes.
    localparam int WORD_DEPTH       = 1024;
    localparam int RECORD_DEPTH     = 64;
    localparam int RECORD_MAX_WORDS = 64;

    // Field widths.
    localparam int DATA_W = 32;
    localparam int WT_W   = $clog2(WORD_DEPTH + 1);
    localparam int WA_W   = $clog2(WORD_DEPTH);
    localparam int RC_W   = $clog2(RECORD_DEPTH + 1);
    localparam int RA_W   = $clog2(RECORD_DEPTH);
    localparam int LEN_W  = $clog2(RECORD_MAX_WORDS + 1);

    // Input kinds carried on the slave tuser.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Result kinds carried on the master tuser.
    typedef enum logic [1:0] {
        ST_WORD     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LRD,
        S_LEN,
        S_RD
    } t_state;

    // Request to the shared address adder.
    typedef struct packed {
        logic [WT_W-1:0] a;
        logic [WT_W-1:0] b;
        logic            sub;
    } t_alu_req;

endpackage

### hdl/frame_stack.sv
// Last-in first-out stack of variable-length records of signed 32-bit words.
// Slave channel: tdata is the word, tuser the kind (0 push, 1 pop), tlast
// closes the open record on a push. Master channel: tdata is the popped word
// (zero for status beats), tuser the status (0 word, 1 empty stack,
// 2 overflow drop), tlast marks the final beat caused by one input beat.
// A push keeps the block in the idle state; it is ready again in the next cycle
// unless the output register holds a beat not yet taken. A push that is dropped
// gives one overflow beat, otherwise no beat. A pop looks up the record length
// in the length memory (states S_LRD and S_LEN), then streams the record at one
// word per cycle, while the receiver does not stall, through the shared address
// adder and the registered word memory read into the output register. The
// slave side stays not ready until the whole record has been read out.
// Reset (synchronous, active low) empties the stack at once; the memories are
// not cleared and need no clearing pass. When the receiver stalls, the output
// register holds its beat, the read stream pauses, and no input is taken.
module frame_stack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] value
    input  logic [0:0]  i_s_axis_tuser,  // [0] action
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [31:0] word
    output logic [1:0]  o_m_axis_tuser,  // [1:0] status
    output logic        o_m_axis_tlast
);

    import fs_pkg::*;

    t_state             r_state, n_state;
    logic [WT_W-1:0]    r_word_top, n_word_top;
    logic [RC_W-1:0]    r_rec_count, n_rec_count;
    logic               r_open, n_open;
    logic [LEN_W-1:0]   r_open_len, n_open_len;
    logic [WT_W-1:0]    r_addr, n_addr;
    logic [LEN_W-1:0]   r_remain, n_remain;
    logic               r_dvalid, n_dvalid;
    logic               r_dlast, n_dlast;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_out_word, n_out_word;
    t_status            r_out_status, n_out_status;
    logic               r_out_last, n_out_last;

    t_alu_req           w_alu_req;
    logic [WT_W-1:0]    w_alu_res;
    logic               w_wr_we, w_wr_re;
    logic [DATA_W-1:0]  w_wr_rdata;
    logic               w_len_we, w_len_re;
    logic [RA_W-1:0]    w_len_waddr;
    logic [LEN_W-1:0]   w_len_wdata;
    logic [LEN_W-1:0]   w_len_rdata;
    logic               w_out_free;
    logic               w_accept;
    logic               w_out_load;
    logic [LEN_W-1:0]   w_eff_len;
    logic [LEN_W-1:0]   w_new_len;
    logic [LEN_W-1:0]   w_pop_len;
    logic               w_ovf;
    logic               w_close;
    logic [RC_W-1:0]    w_rc_after;

    fs_alu u_alu (
        .i_req    (w_alu_req),
        .o_result (w_alu_res)
    );

    fs_ram #(
        .DEPTH (WORD_DEPTH),
        .WIDTH (DATA_W)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_we),
        .i_waddr (r_word_top[WA_W-1:0]),
        .i_wdata (i_s_axis_tdata),
        .i_re    (w_wr_re),
        .i_raddr (r_addr[WA_W-1:0]),
        .o_rdata (w_wr_rdata)
    );

    fs_ram #(
        .DEPTH (RECORD_DEPTH),
        .WIDTH (LEN_W)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (w_len_we),
        .i_waddr (w_len_waddr),
        .i_wdata (w_len_wdata),
        .i_re    (w_len_re),
        .i_raddr (RA_W'(r_rec_count - RC_W'(1))),
        .o_rdata (w_len_rdata)
    );

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_word;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_word_top  <= '0;
            r_rec_count <= '0;
            r_open      <= 1'b0;
            r_open_len  <= '0;
            r_remain    <= '0;
            r_dvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word_top  <= n_word_top;
            r_rec_count <= n_rec_count;
            r_open      <= n_open;
            r_open_len  <= n_open_len;
            r_remain    <= n_remain;
            r_dvalid    <= n_dvalid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_dlast      <= n_dlast;
        r_out_word   <= n_out_word;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    // Push bookkeeping, shared by the idle state.
    always_comb begin
        w_eff_len = r_open ? r_open_len : '0;
        w_ovf     = (r_word_top == WT_W'(WORD_DEPTH)) ||
                    (w_eff_len >= LEN_W'(RECORD_MAX_WORDS)) ||
                    (r_rec_count >= RC_W'(RECORD_DEPTH));
        w_new_len = w_ovf ? w_eff_len : w_eff_len + LEN_W'(1);
    end

    // Length of the top record, limited to the words held.
    always_comb begin
        if (WT_W'(w_len_rdata) > r_word_top) begin
            w_pop_len = r_word_top[LEN_W-1:0];
        end else begin
            w_pop_len = w_len_rdata;
        end
    end

    // Next state, memory control and output register load.
    always_comb begin
        n_state      = r_state;
        n_word_top   = r_word_top;
        n_rec_count  = r_rec_count;
        n_open       = r_open;
        n_open_len   = r_open_len;
        n_addr       = r_addr;
        n_remain     = r_remain;
        n_dvalid     = r_dvalid;
        n_dlast      = r_dlast;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_word   = r_out_word;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;

        w_alu_req.a   = r_word_top;
        w_alu_req.b   = WT_W'(1);
        w_alu_req.sub = 1'b0;
        w_wr_we       = 1'b0;
        w_wr_re       = 1'b0;
        w_len_we      = 1'b0;
        w_len_re      = 1'b0;
        w_len_waddr   = r_rec_count[RA_W-1:0];
        w_len_wdata   = w_new_len;
        w_close       = 1'b0;
        w_rc_after    = r_rec_count;
        w_out_load    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_s_axis_tuser[0] == ACT_PUSH)) begin
                    // Store the word at the top, or report the drop.
                    if (w_ovf) begin
                        n_out_valid  = 1'b1;
                        n_out_word   = '0;
                        n_out_status = ST_OVERFLOW;
                        n_out_last   = 1'b1;
                    end else begin
                        w_wr_we    = 1'b1;
                        n_word_top = w_alu_res;
                    end
                    if (i_s_axis_tlast) begin
                        if ((w_new_len != '0) && (r_rec_count < RC_W'(RECORD_DEPTH))) begin
                            w_len_we    = 1'b1;
                            n_rec_count = r_rec_count + RC_W'(1);
                        end
                        n_open     = 1'b0;
                        n_open_len = '0;
                    end else begin
                        n_open     = 1'b1;
                        n_open_len = w_new_len;
                    end
                end else if (w_accept) begin
                    // A pop first closes the open record.
                    w_len_wdata = r_open_len;
                    w_close     = r_open && (r_open_len != '0) &&
                                  (r_rec_count < RC_W'(RECORD_DEPTH));
                    if (w_close) begin
                        w_len_we   = 1'b1;
                        w_rc_after = r_rec_count + RC_W'(1);
                    end
                    n_rec_count = w_rc_after;
                    n_open      = 1'b0;
                    n_open_len  = '0;
                    if (w_rc_after == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_word   = '0;
                        n_out_status = ST_EMPTY;
                        n_out_last   = 1'b1;
                    end else begin
                        n_state = S_LRD;
                    end
                end
            end
            S_LRD: begin
                // Fetch the length of the top record.
                w_len_re = 1'b1;
                n_state  = S_LEN;
            end
            S_LEN: begin
                // The record starts that many words below the top.
                w_alu_req.b   = WT_W'(w_pop_len);
                w_alu_req.sub = 1'b1;
                if (w_pop_len == '0) begin
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_word   = '0;
                        n_out_status = ST_EMPTY;
                        n_out_last   = 1'b1;
                        n_rec_count  = r_rec_count - RC_W'(1);
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_word_top  = w_alu_res;
                    n_addr      = w_alu_res;
                    n_remain    = w_pop_len;
                    n_rec_count = r_rec_count - RC_W'(1);
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                // Move the read beat into the output register when it is free.
                w_out_load = r_dvalid && w_out_free;
                if (w_out_load) begin
                    n_out_valid  = 1'b1;
                    n_out_word   = w_wr_rdata;
                    n_out_status = ST_WORD;
                    n_out_last   = r_dlast;
                end
                // Issue the next read once the read register will be empty.
                w_alu_req.a = r_addr;
                w_wr_re     = (r_remain != '0) && (!r_dvalid || w_out_load);
                if (w_wr_re) begin
                    n_addr   = w_alu_res;
                    n_remain = r_remain - LEN_W'(1);
                    n_dlast  = (r_remain == LEN_W'(1));
                end
                n_dvalid = w_wr_re || (r_dvalid && !w_out_load);
                if ((r_remain == '0) && !r_dvalid) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/fs_ram.sv
module fs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One read port with registered data that holds while not enabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/fs_alu.sv
module fs_alu (
    input  fs_pkg::t_alu_req         i_req,
    output logic [fs_pkg::WT_W-1:0]  o_result
);

    import fs_pkg::*;

    // Shared address adder: word top increment, record base and read address step.
    always_comb begin
        if (i_req.sub) begin
            o_result = i_req.a - i_req.b;
        end else begin
            o_result = i_req.a + i_req.b;
        end
    end

endmodule
